// File: rtl/core/lbd_pkg.sv
// lbd_pkg: shared constants for the block buffer directory
// field widths, request codes, status codes and default sizes
// no dependencies
`default_nettype none

package lbd_pkg;

  // default pool geometry
  localparam int LBD_NUM_SLOTS = 32;
  localparam int LBD_MAX_REFS  = 255;

  // fixed field widths
  localparam int LBD_DEV_W  = 8;
  localparam int LBD_BLK_W  = 32;
  localparam int LBD_SLOT_W = 5;
  localparam int LBD_STAT_W = 2;

  // request codes
  localparam logic LBD_REQ_ACQUIRE = 1'b0;
  localparam logic LBD_REQ_RELEASE = 1'b1;

  // result status codes
  localparam logic [LBD_STAT_W-1:0] LBD_ST_OK     = 2'd0;
  localparam logic [LBD_STAT_W-1:0] LBD_ST_NOFREE = 2'd1;
  localparam logic [LBD_STAT_W-1:0] LBD_ST_UNREF  = 2'd2;
  localparam logic [LBD_STAT_W-1:0] LBD_ST_OVF    = 2'd3;

endpackage

`default_nettype wire

// File: rtl/core/lbd_mem.sv
// lbd_mem: directory entry store, one write and one registered read port
// generic, no package dependencies
`default_nettype none

module lbd_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 51
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/core/lbd_ctrl.sv
// lbd_ctrl: request sequencer, entry scans, read-modify-write and result register
// depends on lbd_pkg; drives the ports of lbd_mem
`default_nettype none

module lbd_ctrl
  import lbd_pkg::*;
#(
  parameter int NUM_SLOTS = LBD_NUM_SLOTS,
  parameter int MAX_REFS  = LBD_MAX_REFS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_req_type,
  input  wire logic [LBD_DEV_W-1:0]  in_device,
  input  wire logic [LBD_BLK_W-1:0]  in_block_number,
  input  wire logic [LBD_SLOT_W-1:0] in_slot_in,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [LBD_SLOT_W-1:0]      out_slot_out,
  output logic                       out_tag_hit,
  output logic                       out_fill_needed,
  output logic [LBD_STAT_W-1:0]      out_status,
  // entry store
  output logic                       wr_en,
  output logic [$clog2(NUM_SLOTS)-1:0] wr_addr,
  output logic [LBD_DEV_W+LBD_BLK_W+1+$clog2(MAX_REFS+1)+$clog2(NUM_SLOTS)-1:0] wr_data,
  output logic                       rd_en,
  output logic [$clog2(NUM_SLOTS)-1:0] rd_addr,
  input  wire logic [LBD_DEV_W+LBD_BLK_W+1+$clog2(MAX_REFS+1)+$clog2(NUM_SLOTS)-1:0] rd_data
);

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(MAX_REFS + 1);

  typedef struct packed {
    logic [LBD_DEV_W-1:0] dev;
    logic [LBD_BLK_W-1:0] blk;
    logic                 valid;
    logic [CW-1:0]        refs;
    logic [SW-1:0]        rank;
  } entry_t;

  typedef enum logic [7:0] {
    ST_CLEAR   = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_SCAN    = 8'b0000_0100,
    ST_ACQ_END = 8'b0000_1000,
    ST_REL_RD  = 8'b0001_0000,
    ST_REL_CHK = 8'b0010_0000,
    ST_SWEEP   = 8'b0100_0000,
    ST_RESP    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [SW:0]   cnt_r, cnt_nxt;
  logic          pv_r, pv_nxt;
  logic [SW-1:0] pidx_r, pidx_nxt;

  logic [LBD_DEV_W-1:0]  dev_r, dev_nxt;
  logic [LBD_BLK_W-1:0]  blk_r, blk_nxt;
  logic [LBD_SLOT_W-1:0] slot_r, slot_nxt;

  logic          hit_found_r, hit_found_nxt;
  logic [SW-1:0] hit_idx_r, hit_idx_nxt;
  entry_t        hit_ent_r, hit_ent_nxt;
  logic          free_found_r, free_found_nxt;
  logic [SW-1:0] free_idx_r, free_idx_nxt;
  logic [SW-1:0] free_rank_r, free_rank_nxt;
  logic [SW-1:0] old_rank_r, old_rank_nxt;

  logic [LBD_SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic                  res_hit_r, res_hit_nxt;
  logic                  res_fill_r, res_fill_nxt;
  logic [LBD_STAT_W-1:0] res_stat_r, res_stat_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [LBD_SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic                  out_hit_r, out_hit_nxt;
  logic                  out_fill_r, out_fill_nxt;
  logic [LBD_STAT_W-1:0] out_stat_r, out_stat_nxt;

  entry_t  rd_ent, wr_ent;
  logic    in_acc;
  logic    scan_last;
  logic    is_match, is_free;

  assign rd_ent    = entry_t'(rd_data);
  assign wr_data   = wr_ent;
  assign in_acc    = in_valid && in_ready;
  assign scan_last = (cnt_r == (SW+1)'(NUM_SLOTS)) && pv_r;
  assign is_match  = (rd_ent.dev == dev_r) && (rd_ent.blk == blk_r);
  assign is_free   = (rd_ent.refs == '0);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pv_nxt         = 1'b0;
    pidx_nxt       = pidx_r;
    dev_nxt        = dev_r;
    blk_nxt        = blk_r;
    slot_nxt       = slot_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_ent_nxt    = hit_ent_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    free_rank_nxt  = free_rank_r;
    old_rank_nxt   = old_rank_r;
    res_slot_nxt   = res_slot_r;
    res_hit_nxt    = res_hit_r;
    res_fill_nxt   = res_fill_r;
    res_stat_nxt   = res_stat_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_slot_nxt   = out_slot_r;
    out_hit_nxt    = out_hit_r;
    out_fill_nxt   = out_fill_r;
    out_stat_nxt   = out_stat_r;
    wr_en          = 1'b0;
    wr_addr        = cnt_r[SW-1:0];
    wr_ent         = rd_ent;
    rd_en          = 1'b0;
    rd_addr        = cnt_r[SW-1:0];
    in_ready       = (state_r == ST_IDLE);

    case (state_r)
      ST_CLEAR: begin
        // write the reset image, highest slot most recent
        wr_en       = 1'b1;
        wr_ent      = '0;
        wr_ent.rank = SW'(NUM_SLOTS - 1) - cnt_r[SW-1:0];
        if (cnt_r == (SW+1)'(NUM_SLOTS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          dev_nxt        = in_device;
          blk_nxt        = in_block_number;
          slot_nxt       = in_slot_in;
          cnt_nxt        = '0;
          hit_found_nxt  = 1'b0;
          free_found_nxt = 1'b0;
          if (in_req_type == LBD_REQ_ACQUIRE) begin
            state_nxt = ST_SCAN;
          end else if (32'(in_slot_in) < 32'(NUM_SLOTS)) begin
            state_nxt = ST_REL_RD;
          end else begin
            res_slot_nxt = in_slot_in;
            res_hit_nxt  = 1'b0;
            res_fill_nxt = 1'b0;
            res_stat_nxt = LBD_ST_UNREF;
            state_nxt    = ST_RESP;
          end
        end
      end

      ST_SCAN, ST_SWEEP: begin
        if (cnt_r != (SW+1)'(NUM_SLOTS)) begin
          rd_en    = 1'b1;
          pv_nxt   = 1'b1;
          pidx_nxt = cnt_r[SW-1:0];
          cnt_nxt  = cnt_r + 1'b1;
        end
        if (state_r == ST_SCAN) begin
          if (pv_r) begin
            if (is_match && (!hit_found_r || rd_ent.rank < hit_ent_r.rank)) begin
              hit_found_nxt = 1'b1;
              hit_idx_nxt   = pidx_r;
              hit_ent_nxt   = rd_ent;
            end
            if (is_free && (!free_found_r || rd_ent.rank > free_rank_r)) begin
              free_found_nxt = 1'b1;
              free_idx_nxt   = pidx_r;
              free_rank_nxt  = rd_ent.rank;
            end
          end
          if (scan_last) begin
            state_nxt = ST_ACQ_END;
          end
        end else begin
          // move the released slot to the front, age the ones ahead of it
          if (pv_r) begin
            wr_en   = 1'b1;
            wr_addr = pidx_r;
            if (pidx_r == SW'(slot_r)) begin
              wr_ent.refs = '0;
              wr_ent.rank = '0;
            end else if (rd_ent.rank < old_rank_r) begin
              wr_ent.rank = rd_ent.rank + 1'b1;
            end
          end
          if (scan_last) begin
            res_slot_nxt = slot_r;
            res_hit_nxt  = 1'b0;
            res_fill_nxt = 1'b0;
            res_stat_nxt = LBD_ST_OK;
            state_nxt    = ST_RESP;
          end
        end
      end

      ST_ACQ_END: begin
        state_nxt = ST_RESP;
        if (hit_found_r) begin
          res_slot_nxt = LBD_SLOT_W'(hit_idx_r);
          res_hit_nxt  = 1'b1;
          if (hit_ent_r.refs >= CW'(MAX_REFS)) begin
            res_fill_nxt = 1'b0;
            res_stat_nxt = LBD_ST_OVF;
          end else begin
            wr_en        = 1'b1;
            wr_addr      = hit_idx_r;
            wr_ent       = hit_ent_r;
            wr_ent.refs  = hit_ent_r.refs + 1'b1;
            wr_ent.valid = 1'b1;
            res_fill_nxt = !hit_ent_r.valid;
            res_stat_nxt = LBD_ST_OK;
          end
        end else if (free_found_r) begin
          wr_en        = 1'b1;
          wr_addr      = free_idx_r;
          wr_ent.dev   = dev_r;
          wr_ent.blk   = blk_r;
          wr_ent.valid = 1'b1;
          wr_ent.refs  = CW'(1);
          wr_ent.rank  = free_rank_r;
          res_slot_nxt = LBD_SLOT_W'(free_idx_r);
          res_hit_nxt  = 1'b0;
          res_fill_nxt = 1'b1;
          res_stat_nxt = LBD_ST_OK;
        end else begin
          res_slot_nxt = '0;
          res_hit_nxt  = 1'b0;
          res_fill_nxt = 1'b0;
          res_stat_nxt = LBD_ST_NOFREE;
        end
      end

      ST_REL_RD: begin
        rd_en     = 1'b1;
        rd_addr   = SW'(slot_r);
        state_nxt = ST_REL_CHK;
      end

      ST_REL_CHK: begin
        res_slot_nxt = slot_r;
        res_hit_nxt  = 1'b0;
        res_fill_nxt = 1'b0;
        if (rd_ent.refs == '0) begin
          res_stat_nxt = LBD_ST_UNREF;
          state_nxt    = ST_RESP;
        end else if (rd_ent.refs == CW'(1)) begin
          old_rank_nxt = rd_ent.rank;
          cnt_nxt      = '0;
          state_nxt    = ST_SWEEP;
        end else begin
          wr_en        = 1'b1;
          wr_addr      = SW'(slot_r);
          wr_ent.refs  = rd_ent.refs - 1'b1;
          res_stat_nxt = LBD_ST_OK;
          state_nxt    = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = res_slot_r;
          out_hit_nxt   = res_hit_r;
          out_fill_nxt  = res_fill_r;
          out_stat_nxt  = res_stat_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r       <= pidx_nxt;
    dev_r        <= dev_nxt;
    blk_r        <= blk_nxt;
    slot_r       <= slot_nxt;
    hit_found_r  <= hit_found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_ent_r    <= hit_ent_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    free_rank_r  <= free_rank_nxt;
    old_rank_r   <= old_rank_nxt;
    res_slot_r   <= res_slot_nxt;
    res_hit_r    <= res_hit_nxt;
    res_fill_r   <= res_fill_nxt;
    res_stat_r   <= res_stat_nxt;
    out_slot_r   <= out_slot_nxt;
    out_hit_r    <= out_hit_nxt;
    out_fill_r   <= out_fill_nxt;
    out_stat_r   <= out_stat_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_slot_out    = out_slot_r;
  assign out_tag_hit     = out_hit_r;
  assign out_fill_needed = out_fill_r;
  assign out_status      = out_stat_r;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("request taken during the clearing pass");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !wr_en)
    else $error("entry store written while idle");

  a_fill_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fill_r) |-> (out_stat_r == LBD_ST_OK))
    else $error("fill flagged on a failed request");

  a_nofree_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stat_r == LBD_ST_NOFREE) |-> (out_slot_r == '0 && !out_hit_r))
    else $error("no-free result carries a slot or a hit");

endmodule

`default_nettype wire

// File: rtl/core/lru_block_buffer_directory.sv
// acquire: one scan of the entry store between accept and result valid
// release: one entry read and checked, then a write back or, when the count drops to zero, the recency sweep
// throughput: one request at a time; in_ready is high only while the sequencer is idle
// reset: synchronous rst_n low, then a clearing pass writes the reset image to every entry;
// in_ready stays low until it completes
// top level of the block buffer directory; depends on lbd_pkg, lbd_mem and lbd_ctrl
`default_nettype none

module lru_block_buffer_directory
  import lbd_pkg::*;
#(
  parameter int NUM_SLOTS = LBD_NUM_SLOTS,
  parameter int MAX_REFS  = LBD_MAX_REFS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request channel: acquire by tag or release by slot
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_req_type,
  input  wire logic [LBD_DEV_W-1:0]  in_device,
  input  wire logic [LBD_BLK_W-1:0]  in_block_number,
  input  wire logic [LBD_SLOT_W-1:0] in_slot_in,
  // result channel, one result per request
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [LBD_SLOT_W-1:0]      out_slot_out,
  output logic                       out_tag_hit,
  output logic                       out_fill_needed,
  output logic [LBD_STAT_W-1:0]      out_status
);

  // one entry word: device tag, block tag, valid mark, reference count, recency rank
  localparam int SW      = $clog2(NUM_SLOTS);
  localparam int ENTRY_W = LBD_DEV_W + LBD_BLK_W + 1 + $clog2(MAX_REFS + 1) + SW;

  logic               wr_en;
  logic [SW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               rd_en;
  logic [SW-1:0]      rd_addr;
  logic [ENTRY_W-1:0] rd_data;

  // sequencer: scans the store once per acquire, tracking the most recent tag match
  // and the least recent unreferenced entry side by side, then writes back at most one entry;
  // release is a read-modify-write of one entry, plus a full rank sweep on last release
  lbd_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .MAX_REFS  (MAX_REFS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_device       (in_device),
    .in_block_number (in_block_number),
    .in_slot_in      (in_slot_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_slot_out    (out_slot_out),
    .out_tag_hit     (out_tag_hit),
    .out_fill_needed (out_fill_needed),
    .out_status      (out_status),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data)
  );

  // entry store; a read lands in the cycle after its address, sweep writes trail reads by one
  // entry so a location is never read and written in the same cycle
  lbd_mem #(
    .DEPTH (NUM_SLOTS),
    .WIDTH (ENTRY_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

// File: dv/testbench.sv
// testbench for lru_block_buffer_directory: table of directed requests, scripted pool
// scenarios and random traffic, each result checked against a typed row or a behavioural directory model
// depends on lbd_pkg and the rtl of the block

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lbd_pkg::*;

  localparam int NUM_SLOTS     = LBD_NUM_SLOTS;
  localparam int MAX_REFS      = LBD_MAX_REFS;
  localparam int ITEM_TARGET   = 650;
  localparam int IDLE_PCT      = 23;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = NUM_SLOTS + 8;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int N_DIRECTED    = 20;

  // one result of the directory, laid out as the result port fields
  typedef struct packed {
    logic [LBD_SLOT_W-1:0] slot;
    logic                  hit;
    logic                  fill;
    logic [LBD_STAT_W-1:0] status;
  } dir_result_t;

  // one row of the directed table; typed rows carry their own expected result
  typedef struct packed {
    logic                  req;
    logic [LBD_DEV_W-1:0]  dev;
    logic [LBD_BLK_W-1:0]  blk;
    logic [LBD_SLOT_W-1:0] slot;
    logic                  typed;
    dir_result_t           res;
  } stim_row_t;

  localparam dir_result_t UNTYPED = '0;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_req_type = LBD_REQ_ACQUIRE;
  logic [LBD_DEV_W-1:0]  in_device = '0;
  logic [LBD_BLK_W-1:0]  in_block_number = '0;
  logic [LBD_SLOT_W-1:0] in_slot_in = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [LBD_SLOT_W-1:0] out_slot_out;
  logic                  out_tag_hit;
  logic                  out_fill_needed;
  logic [LBD_STAT_W-1:0] out_status;

  // directory image kept by the testbench
  logic [LBD_DEV_W-1:0] pool_dev    [NUM_SLOTS];
  logic [LBD_BLK_W-1:0] pool_blk    [NUM_SLOTS];
  logic                 pool_filled [NUM_SLOTS];
  int unsigned          pool_refs   [NUM_SLOTS];
  int unsigned          pool_rank   [NUM_SLOTS];

  dir_result_t awaited_results [$];
  dir_result_t want;
  stim_row_t   directed_rows [N_DIRECTED];

  // stall control set by the main sequence, read by the request task and the result-side process
  bit src_quiet  = 1'b0;
  bit sink_quiet = 1'b0;
  int sink_hold_request = 0;

  int cycle_count = 0;
  int sent_count  = 0;
  int fail_count  = 0;
  int n_hits = 0, n_fills = 0, n_nofree = 0, n_ovf = 0, n_released = 0, n_unref = 0;

  lru_block_buffer_directory dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_device       (in_device),
    .in_block_number (in_block_number),
    .in_slot_in      (in_slot_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_slot_out    (out_slot_out),
    .out_tag_hit     (out_tag_hit),
    .out_fill_needed (out_fill_needed),
    .out_status      (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // behaviour of one request on the directory image, returns what the block should answer
  function automatic dir_result_t predict_directory(input logic req,
                                                    input logic [LBD_DEV_W-1:0] dev,
                                                    input logic [LBD_BLK_W-1:0] blk,
                                                    input logic [LBD_SLOT_W-1:0] slot);
    dir_result_t r;
    int          best;
    int unsigned old_rank;
    r    = '0;
    best = -1;
    if (req == LBD_REQ_ACQUIRE) begin
      // tag search, most recent match wins; the valid mark plays no part
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (pool_dev[i] == dev && pool_blk[i] == blk &&
            (best < 0 || pool_rank[i] < pool_rank[best])) best = i;
      end
      if (best >= 0) begin
        r.slot = LBD_SLOT_W'(best);
        r.hit  = 1'b1;
        if (pool_refs[best] >= MAX_REFS) begin
          // saturated count: nothing changes
          r.status = LBD_ST_OVF;
        end else begin
          pool_refs[best]++;
          r.fill            = !pool_filled[best];
          pool_filled[best] = 1'b1;
          r.status          = LBD_ST_OK;
        end
        return r;
      end
      // miss: reuse the least recent unreferenced entry, ranks untouched
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (pool_refs[i] == 0 && (best < 0 || pool_rank[i] > pool_rank[best])) best = i;
      end
      if (best < 0) begin
        r.status = LBD_ST_NOFREE;
        return r;
      end
      pool_dev[best]    = dev;
      pool_blk[best]    = blk;
      pool_refs[best]   = 1;
      pool_filled[best] = 1'b1;
      r.slot   = LBD_SLOT_W'(best);
      r.fill   = 1'b1;
      r.status = LBD_ST_OK;
    end else begin
      r.slot = slot;
      if (slot >= NUM_SLOTS || pool_refs[slot] == 0) begin
        r.status = LBD_ST_UNREF;
      end else begin
        pool_refs[slot]--;
        if (pool_refs[slot] == 0) begin
          // last reference gone: slot becomes most recent
          old_rank = pool_rank[slot];
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (pool_rank[i] < old_rank) pool_rank[i]++;
          end
          pool_rank[slot] = 0;
        end
        r.status = LBD_ST_OK;
      end
    end
    return r;
  endfunction

  function automatic int unreferenced_slots();
    int n;
    n = 0;
    foreach (pool_refs[i]) if (pool_refs[i] == 0) n++;
    return n;
  endfunction

  // drive one request from a falling edge, hold it until accepted, then log its answer
  task automatic issue_request(input logic req, input logic [LBD_DEV_W-1:0] dev,
                               input logic [LBD_BLK_W-1:0] blk,
                               input logic [LBD_SLOT_W-1:0] slot,
                               input logic typed, input dir_result_t typed_res);
    dir_result_t predicted;
    @(negedge clk);
    while (!src_quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_device       <= dev;
    in_block_number <= blk;
    in_slot_in      <= slot;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    // accepted at this edge; the image is current before the next request is chosen
    predicted = predict_directory(req, dev, blk, slot);
    if (req == LBD_REQ_RELEASE) begin
      if (predicted.status == LBD_ST_OK) n_released++;
      else n_unref++;
    end else begin
      case (predicted.status)
        LBD_ST_NOFREE: n_nofree++;
        LBD_ST_OVF:    n_ovf++;
        default: begin
          if (predicted.hit) n_hits++;
          else n_fills++;
        end
      endcase
    end
    awaited_results.push_back(typed ? typed_res : predicted);
    sent_count++;
  endtask

  task automatic acquire_block(input logic [LBD_DEV_W-1:0] dev,
                               input logic [LBD_BLK_W-1:0] blk);
    issue_request(LBD_REQ_ACQUIRE, dev, blk, '0, 1'b0, UNTYPED);
  endtask

  task automatic drop_slot(input logic [LBD_SLOT_W-1:0] slot);
    issue_request(LBD_REQ_RELEASE, '0, '0, slot, 1'b0, UNTYPED);
  endtask

  // sender stands still until every outstanding request has answered
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
  endtask

  // result side: random back-pressure, long hold-off on request, quiet stretches
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (sink_hold_request > 0) begin
        hold_left         = sink_hold_request;
        sink_hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (sink_quiet) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // result checker, oldest outstanding request first
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, nothing outstanding (slot %0d status %0d)",
                 $time, out_slot_out, out_status);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_slot_out !== want.slot) begin
          $display("%0t: slot_out mismatch, expected %0d, got %0d",
                   $time, want.slot, out_slot_out);
          fail_count++;
        end
        if (out_tag_hit !== want.hit) begin
          $display("%0t: tag_hit mismatch, expected %0d, got %0d",
                   $time, want.hit, out_tag_hit);
          fail_count++;
        end
        if (out_fill_needed !== want.fill) begin
          $display("%0t: fill_needed mismatch, expected %0d, got %0d",
                   $time, want.fill, out_fill_needed);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, out_status);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run stuck after %0d cycles, %0d results outstanding",
             $time, CYCLE_LIMIT, awaited_results.size());
    $display("Verification failed");
    $finish;
  end

  // main sequence
  initial begin
    int          guard;
    int          ovf_slot;
    int          acq_bias;
    int          pick;
    logic [LBD_SLOT_W-1:0] held [$];

    // reset image: all tags device 0 block 0, highest slot most recent
    for (int i = 0; i < NUM_SLOTS; i++) begin
      pool_dev[i]    = '0;
      pool_blk[i]    = '0;
      pool_filled[i] = 1'b0;
      pool_refs[i]   = 0;
      pool_rank[i]   = NUM_SLOTS - 1 - i;
    end

    // directed table: field extremes, both request kinds, the simple special cases
    directed_rows = '{
      // (0,0) after reset hits the most recent never-filled entry
      '{LBD_REQ_ACQUIRE, 8'h00, 32'h0000_0000, 5'd0,  1'b1, '{5'd31, 1'b1, 1'b1, LBD_ST_OK}},
      '{LBD_REQ_ACQUIRE, 8'h00, 32'h0000_0000, 5'd0,  1'b1, '{5'd31, 1'b1, 1'b0, LBD_ST_OK}},
      '{LBD_REQ_RELEASE, 8'h00, 32'h0000_0000, 5'd31, 1'b1, '{5'd31, 1'b0, 1'b0, LBD_ST_OK}},
      '{LBD_REQ_RELEASE, 8'h00, 32'h0000_0000, 5'd31, 1'b1, '{5'd31, 1'b0, 1'b0, LBD_ST_OK}},
      // release with no reference left
      '{LBD_REQ_RELEASE, 8'h00, 32'h0000_0000, 5'd31, 1'b1,
        '{5'd31, 1'b0, 1'b0, LBD_ST_UNREF}},
      '{LBD_REQ_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd0,  1'b1, '{5'd0, 1'b0, 1'b0, LBD_ST_UNREF}},
      // first real miss takes the least recent entry
      '{LBD_REQ_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 5'd0,  1'b1, '{5'd0, 1'b0, 1'b1, LBD_ST_OK}},
      '{LBD_REQ_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 5'd31, 1'b0, UNTYPED},
      '{LBD_REQ_ACQUIRE, 8'hA5, 32'h5A5A_5A5A, 5'd0,  1'b0, UNTYPED},
      '{LBD_REQ_ACQUIRE, 8'h5A, 32'hA5A5_A5A5, 5'd0,  1'b0, UNTYPED},
      '{LBD_REQ_ACQUIRE, 8'h00, 32'h0000_0000, 5'd0,  1'b0, UNTYPED},
      '{LBD_REQ_ACQUIRE, 8'h80, 32'h8000_0000, 5'd0,  1'b0, UNTYPED},
      '{LBD_REQ_ACQUIRE, 8'h01, 32'h0000_0001, 5'd0,  1'b0, UNTYPED},
      '{LBD_REQ_RELEASE, 8'h00, 32'h0000_0000, 5'd0,  1'b0, UNTYPED},
      // count to zero moves slot 0 from least to most recent
      '{LBD_REQ_RELEASE, 8'h00, 32'h0000_0000, 5'd0,  1'b0, UNTYPED},
      '{LBD_REQ_ACQUIRE, 8'h00, 32'h0000_0001, 5'd0,  1'b0, UNTYPED},
      '{LBD_REQ_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 5'd0,  1'b0, UNTYPED},
      '{LBD_REQ_RELEASE, 8'h00, 32'h0000_0000, 5'd31, 1'b0, UNTYPED},
      '{LBD_REQ_RELEASE, 8'h00, 32'h0000_0000, 5'd21, 1'b0, UNTYPED},
      '{LBD_REQ_ACQUIRE, 8'h7F, 32'h7FFF_FFFF, 5'd10, 1'b0, UNTYPED}
    };

    // synchronous reset, then the block runs its clearing pass
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      issue_request(directed_rows[r].req, directed_rows[r].dev, directed_rows[r].blk,
                    directed_rows[r].slot, directed_rows[r].typed, directed_rows[r].res);
    end
    wait_for_results();

    // reference overflow: one tag acquired until its count saturates, no idling on either side
    src_quiet  = 1'b1;
    sink_quiet = 1'b1;
    repeat (MAX_REFS + 2) acquire_block(8'h3C, 32'hC3C3_C3C3);
    ovf_slot = 0;
    foreach (pool_refs[i]) if (pool_refs[i] == MAX_REFS) ovf_slot = i;
    drop_slot(LBD_SLOT_W'(ovf_slot));
    repeat (2) acquire_block(8'h3C, 32'hC3C3_C3C3);
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
    wait_for_results();

    // pool exhaustion while the result side holds off, so the block backs up its input
    sink_hold_request = HOLD_CYCLES;
    guard = 0;
    while (unreferenced_slots() > 0 && guard < 3 * NUM_SLOTS) begin
      acquire_block(LBD_DEV_W'($urandom), $urandom);
      guard++;
    end
    repeat (4) acquire_block(LBD_DEV_W'($urandom), $urandom);
    // a held tag still hits with the pool full
    acquire_block(pool_dev[NUM_SLOTS / 2], pool_blk[NUM_SLOTS / 2]);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      while (pool_refs[i] > 0 && pool_refs[i] < 16) drop_slot(LBD_SLOT_W'(i));
    end
    wait_for_results();

    // random traffic: a small hot tag set for hits, fresh tags for misses,
    // releases mostly of held slots; acquire weight swings so the pool fills and drains
    acq_bias = 35;
    while (sent_count < ITEM_TARGET) begin
      if (sent_count % 40 == 0) acq_bias = (acq_bias == 70) ? 35 : 70;
      src_quiet  = (sent_count >= 480 && sent_count < 530);
      sink_quiet = src_quiet;
      pick = $urandom_range(0, 99);
      if (pick < acq_bias) begin
        if ($urandom_range(0, 3) == 0) begin
          acquire_block(LBD_DEV_W'($urandom), $urandom);
        end else begin
          acquire_block(LBD_DEV_W'($urandom_range(0, 3)), LBD_BLK_W'($urandom_range(0, 7)));
        end
      end else begin
        held.delete();
        foreach (pool_refs[i]) if (pool_refs[i] != 0) held.push_back(LBD_SLOT_W'(i));
        if (held.size() != 0 && $urandom_range(0, 4) != 0) begin
          drop_slot(held[$urandom_range(0, held.size() - 1)]);
        end else begin
          drop_slot(LBD_SLOT_W'($urandom));
        end
      end
    end
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;

    // drain, then leave room for a late recency sweep or a stray result
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d requests: %0d tag hits, %0d refills, %0d pool-full refusals, %0d overflows",
             sent_count, n_hits, n_fills, n_nofree, n_ovf);
    $display("%0d releases taken, %0d refused as unreferenced, %0d mismatches",
             n_released, n_unref, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
